// ===== hw/rtl/npcm_pkg.sv =====
// Shared constants and types for the nearest palette color mapper.
// No dependencies; imported by the top level, the minimum tree and the checker.
package npcm_pkg;

    // Palette geometry
    localparam int PALETTE_DEPTH = 16;
    localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int LEVELS        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 0;
    localparam int LEAVES        = 1 << LEVELS;

    // Field widths
    localparam int COMP_W  = 8;
    localparam int COLOR_W = 3 * COMP_W;
    localparam int SQ_W    = 2 * COMP_W;
    localparam int DIST_W  = 18;
    localparam int CNT_W   = 5;
    localparam int SLOT_W  = 4;

    // Largest possible squared distance: three components at full swing
    localparam int COMPONENT_MAX = 255;
    localparam int DIST_MAX      = 3 * COMPONENT_MAX * COMPONENT_MAX;

    // Pipeline stages: squares, sums, then one per tree level
    localparam int NSTG = LEVELS + 2;

    // Request opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // One candidate in the minimum search
    typedef struct packed {
        logic               en;
        logic [DIST_W-1:0]  sq_sum;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
    } t_node;

endpackage

// ===== hw/rtl/npcm_min_tree.sv =====
// Registered pairwise minimum tree over the palette lanes, one level per stage.
// Depends on npcm_pkg for t_node and the tree geometry.
module npcm_min_tree (
    input  logic            i_clk,
    input  logic            i_en,
    input  npcm_pkg::t_node i_leaf [npcm_pkg::LEAVES],
    output npcm_pkg::t_node o_root
);
    import npcm_pkg::*;

    // Keep the left (lower index) candidate unless the right one is strictly closer
    function automatic t_node pick(input t_node l, input t_node r);
        t_node res;
        res = l;
        if (r.en && (!l.en || (r.sq_sum < l.sq_sum))) begin
            res = r;
        end
        res.en = l.en | r.en;
        return res;
    endfunction

    generate
        if (LEVELS == 0) begin : g_single
            // Single entry: nothing to compare
            assign o_root = i_leaf[0];
        end else begin : g_tree
            t_node w_kid [2*LEAVES-1];
            t_node r_int [LEAVES-1];

            // Heap layout: internal nodes first, leaves after them
            for (genvar n = 0; n < LEAVES - 1; n++) begin : g_int_map
                assign w_kid[n] = r_int[n];
            end
            for (genvar j = 0; j < LEAVES; j++) begin : g_leaf_map
                assign w_kid[LEAVES-1+j] = i_leaf[j];
            end

            // Advance every level together; hold on stall
            for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_int[n] <= pick(w_kid[2*n+1], w_kid[2*n+2]);
                    end
                end
            end

            assign o_root = r_int[0];
        end
    endgenerate

endmodule

// ===== hw/rtl/nearest_palette_color_mapper_top.sv =====
// Top level of the nearest palette color mapper: palette, distance lanes, handshakes.
// Depends on npcm_pkg and instantiates npcm_min_tree.
//
//  channel   direction  handshake                  payload
//  input     in         i_valid / o_ready          i_op, i_entry_index, i_red, i_green,
//                                                  i_blue, i_frame_end
//  output    out        o_valid / i_ready          o_out_red, o_out_green, o_out_blue,
//                                                  o_chosen_index, o_distance_sq,
//                                                  o_frame_end_out
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (palette_count)
//
// One request is accepted per cycle while the output is not stalled. A pixel result
// passes the squares stage, which loads at acceptance, then one stage of sums and one
// per level of the minimum tree.
// Loads write the palette at acceptance and give no result.
// Synchronous active-low reset zeroes the palette and the count and drops all valids.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module nearest_palette_color_mapper_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [npcm_pkg::SLOT_W-1:0] i_entry_index,
    input  logic [npcm_pkg::COMP_W-1:0] i_red,
    input  logic [npcm_pkg::COMP_W-1:0] i_green,
    input  logic [npcm_pkg::COMP_W-1:0] i_blue,
    input  logic                        i_frame_end,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [npcm_pkg::COMP_W-1:0] o_out_red,
    output logic [npcm_pkg::COMP_W-1:0] o_out_green,
    output logic [npcm_pkg::COMP_W-1:0] o_out_blue,
    output logic [npcm_pkg::SLOT_W-1:0] o_chosen_index,
    output logic [npcm_pkg::DIST_W-1:0] o_distance_sq,
    output logic                        o_frame_end_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [npcm_pkg::CNT_W-1:0]  i_cfg_data
);
    import npcm_pkg::*;

    typedef struct packed {
        logic               en;
        logic [SQ_W-1:0]    sr;
        logic [SQ_W-1:0]    sg;
        logic [SQ_W-1:0]    sb;
        logic [COLOR_W-1:0] color;
    } t_sq;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                                input logic [COMP_W-1:0] b);
        logic [COMP_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    logic [COLOR_W-1:0] r_palette [PALETTE_DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [NSTG-1:0]    r_vld;
    logic [NSTG-1:0]    r_fe;
    t_sq                r_sq   [LEAVES];
    t_node              r_leaf [LEAVES];
    t_node              w_root;
    logic               w_en;
    logic               w_in_acc;

    // Global advance: move unless a result waits and is not taken
    assign w_en     = !r_vld[NSTG-1] || i_ready;
    assign o_ready  = w_en;
    assign w_in_acc = i_valid && o_ready;

    // Configuration register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    // Write a palette entry on an accepted load; slots beyond the depth are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PALETTE_DEPTH; j++) begin
                r_palette[j] <= '0;
            end
        end else if (w_in_acc && (i_op == OP_LOAD)) begin
            for (int j = 0; j < PALETTE_DEPTH; j++) begin
                if (32'(i_entry_index) == j) begin
                    r_palette[j] <= {i_red, i_green, i_blue};
                end
            end
        end
    end

    // Valid and frame-end marks travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], w_in_acc && (i_op == OP_PIXEL)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fe <= {r_fe[NSTG-2:0], i_frame_end};
        end
    end

    generate
        for (genvar j = 0; j < LEAVES; j++) begin : g_lane
            if (j < PALETTE_DEPTH) begin : g_real
                logic w_on;

                // Entry 0 is always searched; others up to the count
                assign w_on = (j == 0) || (j < int'(r_count));

                // Squared component differences against the current palette
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_sq[j].en    <= w_on;
                        r_sq[j].sr    <= sq_diff(r_palette[j][3*COMP_W-1:2*COMP_W], i_red);
                        r_sq[j].sg    <= sq_diff(r_palette[j][2*COMP_W-1:COMP_W], i_green);
                        r_sq[j].sb    <= sq_diff(r_palette[j][COMP_W-1:0], i_blue);
                        r_sq[j].color <= r_palette[j];
                    end
                end
            end else begin : g_pad
                // Padding lane never wins
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_sq[j] <= '0;
                    end
                end
            end

            // Sum the squares into the tree leaf
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_leaf[j].en     <= r_sq[j].en;
                    r_leaf[j].sq_sum <= DIST_W'(r_sq[j].sr) + DIST_W'(r_sq[j].sg)
                                      + DIST_W'(r_sq[j].sb);
                    r_leaf[j].idx    <= IDX_W'(j);
                    r_leaf[j].color  <= r_sq[j].color;
                end
            end
        end
    endgenerate

    npcm_min_tree u_tree (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_leaf (r_leaf),
        .o_root (w_root)
    );

    // Drive the result from the tree root
    assign o_valid         = r_vld[NSTG-1];
    assign o_out_red       = w_root.color[3*COMP_W-1:2*COMP_W];
    assign o_out_green     = w_root.color[2*COMP_W-1:COMP_W];
    assign o_out_blue      = w_root.color[COMP_W-1:0];
    assign o_chosen_index  = SLOT_W'(w_root.idx);
    assign o_distance_sq   = w_root.sq_sum;
    assign o_frame_end_out = r_fe[NSTG-1];

endmodule

// ===== hw/rtl/npcm_checker.sv =====
// Port-level checker for the nearest palette color mapper, bound to the top level.
// Depends on npcm_pkg for field widths and the distance bound.
module npcm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [npcm_pkg::COMP_W-1:0] o_out_red,
    input logic [npcm_pkg::COMP_W-1:0] o_out_green,
    input logic [npcm_pkg::COMP_W-1:0] o_out_blue,
    input logic [npcm_pkg::SLOT_W-1:0] o_chosen_index,
    input logic [npcm_pkg::DIST_W-1:0] o_distance_sq,
    input logic                        o_frame_end_out
);
    import npcm_pkg::*;

    // Hold a stalled result with its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_red) && $stable(o_out_green)
            && $stable(o_out_blue) && $stable(o_chosen_index)
            && $stable(o_distance_sq) && $stable(o_frame_end_out)))
        else $error("stalled result changed");

    // Refuse requests only while a result waits on the output
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input ready dropped without output stall");

    // Keep the distance within three full-swing components
    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_distance_sq) <= DIST_MAX))
        else $error("distance out of range");

endmodule

bind nearest_palette_color_mapper_top npcm_checker u_npcm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_out_red       (o_out_red),
    .o_out_green     (o_out_green),
    .o_out_blue      (o_out_blue),
    .o_chosen_index  (o_chosen_index),
    .o_distance_sq   (o_distance_sq),
    .o_frame_end_out (o_frame_end_out)
);
